[rtl/orov_pkg.sv]
// ----------------------------------------------------------------------------
// orov_pkg
// Shared constants and request types for the oriented rectangle overlap block.
// ----------------------------------------------------------------------------
package orov_pkg;

  localparam int COORD_WIDTH    = 16;
  localparam int ANGLE_BITS     = 12;
  localparam int TRIG_FRAC_BITS = 14;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] first_center_x;
    logic signed [COORD_WIDTH-1:0] first_center_y;
    logic        [COORD_WIDTH-2:0] first_width;
    logic        [COORD_WIDTH-2:0] first_height;
    logic        [ANGLE_BITS-1:0]  first_angle;
    logic signed [COORD_WIDTH-1:0] second_center_x;
    logic signed [COORD_WIDTH-1:0] second_center_y;
    logic        [COORD_WIDTH-2:0] second_width;
    logic        [COORD_WIDTH-2:0] second_height;
    logic        [ANGLE_BITS-1:0]  second_angle;
  } orov_in_req_t;

  typedef struct packed {
    logic overlap_flag;
    logic covers_flag;
  } orov_out_req_t;

endpackage

[rtl/oriented_rectangle_overlap_top.sv]
// ----------------------------------------------------------------------------
// oriented_rectangle_overlap_top
// Corner containment test between two rotated rectangles.
// ----------------------------------------------------------------------------
// One request on the input channel carries two rectangles (centre, width,
// height, angle); one request on the output channel carries overlap_flag and
// covers_flag for that pair, in order.
// The pipeline has seven register stages and accepts one pair per cycle
// whenever the receiver is not stalling with a result waiting. Stage one
// reads the quarter-wave sine rom, stage two multiplies
// the extents by the rotation, three rounds the corners, four takes offsets
// from the other centre, five rotates them into the other frame, six compares
// against the extents and seven combines the eight corner results.
// Reset clears the valid bits only; the pipeline is empty after reset.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready_o drops; nothing is lost or repeated, and no bubble is
// squeezed out while stalled.
// ----------------------------------------------------------------------------
module oriented_rectangle_overlap_top #(
  parameter int COORD_WIDTH    = orov_pkg::COORD_WIDTH,
  parameter int ANGLE_BITS     = orov_pkg::ANGLE_BITS,
  parameter int TRIG_FRAC_BITS = orov_pkg::TRIG_FRAC_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  orov_pkg::orov_in_req_t in_req_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output orov_pkg::orov_out_req_t out_req_o
);

  localparam int DW    = COORD_WIDTH + 5;
  localparam int TW    = TRIG_FRAC_BITS + 2;
  localparam int DEPTH = 7;

  logic             en;
  logic [DEPTH-1:0] valid_q;

  logic signed [COORD_WIDTH-1:0] fcx_q, fcy_q, scx_q, scy_q;
  logic        [COORD_WIDTH-2:0] fw_q, fh_q, sw_q, sh_q;
  logic signed [TW-1:0]          fsin, fcos, ssin, scos;

  logic signed [TW-1:0]          fsin_q [3], fcos_q [3], ssin_q [3], scos_q [3];
  logic        [COORD_WIDTH-2:0] fw_dq [3], fh_dq [3], sw_dq [3], sh_dq [3];

  logic signed [DW-1:0] sdx [4], sdy [4], fdx [4], fdy [4];
  logic        [3:0]    in_first, in_second;
  orov_pkg::orov_out_req_t out_q;

  assign en         = !valid_q[DEPTH-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[DEPTH-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fcx_q <= in_req_i.first_center_x[COORD_WIDTH-1:0];
      fcy_q <= in_req_i.first_center_y[COORD_WIDTH-1:0];
      fw_q  <= in_req_i.first_width[COORD_WIDTH-2:0];
      fh_q  <= in_req_i.first_height[COORD_WIDTH-2:0];
      scx_q <= in_req_i.second_center_x[COORD_WIDTH-1:0];
      scy_q <= in_req_i.second_center_y[COORD_WIDTH-1:0];
      sw_q  <= in_req_i.second_width[COORD_WIDTH-2:0];
      sh_q  <= in_req_i.second_height[COORD_WIDTH-2:0];
    end
  end

  orov_trig #(
    .ANGLE_BITS     (ANGLE_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_trig_first (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (in_req_i.first_angle[ANGLE_BITS-1:0]),
    .sin_o   (fsin),
    .cos_o   (fcos)
  );

  orov_trig #(
    .ANGLE_BITS     (ANGLE_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_trig_second (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (in_req_i.second_angle[ANGLE_BITS-1:0]),
    .sin_o   (ssin),
    .cos_o   (scos)
  );

  // frame of each rectangle, held until its corners arrive
  always_ff @(posedge clk_i) begin
    if (en) begin
      fsin_q <= {fsin, fsin_q[0:1]};
      fcos_q <= {fcos, fcos_q[0:1]};
      ssin_q <= {ssin, ssin_q[0:1]};
      scos_q <= {scos, scos_q[0:1]};
      fw_dq  <= {fw_q, fw_dq[0:1]};
      fh_dq  <= {fh_q, fh_dq[0:1]};
      sw_dq  <= {sw_q, sw_dq[0:1]};
      sh_dq  <= {sh_q, sh_dq[0:1]};
    end
  end

  orov_corners #(
    .COORD_WIDTH    (COORD_WIDTH),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_corners_second (
    .clk_i    (clk_i),
    .en_i     (en),
    .width_i  (sw_q),
    .height_i (sh_q),
    .cx_i     (scx_q),
    .cy_i     (scy_q),
    .ox_i     (fcx_q),
    .oy_i     (fcy_q),
    .sin_i    (ssin),
    .cos_i    (scos),
    .dx_o     (sdx),
    .dy_o     (sdy)
  );

  orov_corners #(
    .COORD_WIDTH    (COORD_WIDTH),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_corners_first (
    .clk_i    (clk_i),
    .en_i     (en),
    .width_i  (fw_q),
    .height_i (fh_q),
    .cx_i     (fcx_q),
    .cy_i     (fcy_q),
    .ox_i     (scx_q),
    .oy_i     (scy_q),
    .sin_i    (fsin),
    .cos_i    (fcos),
    .dx_o     (fdx),
    .dy_o     (fdy)
  );

  orov_inside #(
    .COORD_WIDTH    (COORD_WIDTH),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_inside_first (
    .clk_i    (clk_i),
    .en_i     (en),
    .dx_i     (sdx),
    .dy_i     (sdy),
    .width_i  (fw_dq[2]),
    .height_i (fh_dq[2]),
    .sin_i    (fsin_q[2]),
    .cos_i    (fcos_q[2]),
    .inside_o (in_first)
  );

  orov_inside #(
    .COORD_WIDTH    (COORD_WIDTH),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_inside_second (
    .clk_i    (clk_i),
    .en_i     (en),
    .dx_i     (fdx),
    .dy_i     (fdy),
    .width_i  (sw_dq[2]),
    .height_i (sh_dq[2]),
    .sin_i    (ssin_q[2]),
    .cos_i    (scos_q[2]),
    .inside_o (in_second)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.overlap_flag <= |in_first || |in_second;
      out_q.covers_flag  <= &in_first;
    end
  end

  assign out_valid_o = valid_q[DEPTH-1];
  assign out_req_o   = out_q;

endmodule

[rtl/orov_trig.sv]
// ----------------------------------------------------------------------------
// orov_trig
// Sine and cosine of a binary-turn angle from a registered quarter-wave rom.
// ----------------------------------------------------------------------------
module orov_trig #(
  parameter int ANGLE_BITS     = orov_pkg::ANGLE_BITS,
  parameter int TRIG_FRAC_BITS = orov_pkg::TRIG_FRAC_BITS
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic        [ANGLE_BITS-1:0]     angle_i,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_o,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_o
);

  localparam int QS = 1 << (ANGLE_BITS - 2);

  typedef logic [TRIG_FRAC_BITS:0] qsin_t [QS+1];

  function automatic qsin_t build_qsin();
    qsin_t tab;
    real   ph;
    real   val;
    for (int r = 0; r <= QS; r++) begin
      ph     = 1.57079632679489661923 * r / QS;
      val    = $floor($sin(ph) * (2.0 ** TRIG_FRAC_BITS) + 0.5);
      tab[r] = (TRIG_FRAC_BITS+1)'($rtoi(val));
    end
    return tab;
  endfunction

  localparam qsin_t QSIN = build_qsin();

  logic [ANGLE_BITS-1:0]     cos_ang;
  logic [ANGLE_BITS-2:0]     sin_idx;
  logic [ANGLE_BITS-2:0]     cos_idx;
  logic [TRIG_FRAC_BITS:0]   sin_rom_q;
  logic [TRIG_FRAC_BITS:0]   cos_rom_q;
  logic                      sin_neg_q;
  logic                      cos_neg_q;

  assign cos_ang = angle_i + ANGLE_BITS'(QS);

  always_comb begin
    sin_idx = angle_i[ANGLE_BITS-2] ?
              (ANGLE_BITS-1)'(QS) - {1'b0, angle_i[ANGLE_BITS-3:0]} :
              {1'b0, angle_i[ANGLE_BITS-3:0]};
    cos_idx = cos_ang[ANGLE_BITS-2] ?
              (ANGLE_BITS-1)'(QS) - {1'b0, cos_ang[ANGLE_BITS-3:0]} :
              {1'b0, cos_ang[ANGLE_BITS-3:0]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_rom_q <= QSIN[sin_idx];
      cos_rom_q <= QSIN[cos_idx];
      sin_neg_q <= angle_i[ANGLE_BITS-1];
      cos_neg_q <= cos_ang[ANGLE_BITS-1];
    end
  end

  assign sin_o = sin_neg_q ? -$signed({1'b0, sin_rom_q}) : $signed({1'b0, sin_rom_q});
  assign cos_o = cos_neg_q ? -$signed({1'b0, cos_rom_q}) : $signed({1'b0, cos_rom_q});

endmodule

[rtl/orov_corners.sv]
// ----------------------------------------------------------------------------
// orov_corners
// Corners of one rectangle as offsets from the other centre, three stages.
// ----------------------------------------------------------------------------
module orov_corners #(
  parameter int COORD_WIDTH    = orov_pkg::COORD_WIDTH,
  parameter int TRIG_FRAC_BITS = orov_pkg::TRIG_FRAC_BITS,
  localparam int DW            = COORD_WIDTH + 5
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic        [COORD_WIDTH-2:0]    width_i,
  input  logic        [COORD_WIDTH-2:0]    height_i,
  input  logic signed [COORD_WIDTH-1:0]    cx_i,
  input  logic signed [COORD_WIDTH-1:0]    cy_i,
  input  logic signed [COORD_WIDTH-1:0]    ox_i,
  input  logic signed [COORD_WIDTH-1:0]    oy_i,
  input  logic signed [TRIG_FRAC_BITS+1:0] sin_i,
  input  logic signed [TRIG_FRAC_BITS+1:0] cos_i,
  output logic signed [DW-1:0]             dx_o [4],
  output logic signed [DW-1:0]             dy_o [4]
);

  localparam int PW = COORD_WIDTH + TRIG_FRAC_BITS + 2;
  localparam int CW = COORD_WIDTH + 4;

  logic signed [PW-1:0]          wc_q, ws_q, hc_q, hs_q;
  logic signed [COORD_WIDTH-1:0] cx_q, cy_q, ox_q, oy_q, ox2_q, oy2_q;
  logic signed [CW-1:0]          px_d [4], py_d [4];
  logic signed [CW-1:0]          px_q [4], py_q [4];
  logic signed [DW-1:0]          dx_q [4], dy_q [4];

  // products of the half extents with the rotation
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wc_q <= $signed({1'b0, width_i}) * cos_i;
      ws_q <= $signed({1'b0, width_i}) * sin_i;
      hc_q <= $signed({1'b0, height_i}) * cos_i;
      hs_q <= $signed({1'b0, height_i}) * sin_i;
      cx_q <= cx_i;
      cy_q <= cy_i;
      ox_q <= ox_i;
      oy_q <= oy_i;
    end
  end

  // rotated offsets, rounded half up, plus doubled centre
  always_comb begin
    logic signed [PW:0] sx, sy, rx, ry;
    for (int k = 0; k < 4; k++) begin
      sx = (k[0] ? (PW+1)'(wc_q) : -(PW+1)'(wc_q)) +
           (k[1] ? -(PW+1)'(hs_q) : (PW+1)'(hs_q));
      sy = (k[1] ? -(PW+1)'(hc_q) : (PW+1)'(hc_q)) -
           (k[0] ? (PW+1)'(ws_q) : -(PW+1)'(ws_q));
      rx = sx + (PW+1)'(1 << (TRIG_FRAC_BITS - 1));
      ry = sy + (PW+1)'(1 << (TRIG_FRAC_BITS - 1));
      px_d[k] = CW'($signed({cx_q, 1'b0})) + CW'($signed(rx[PW:TRIG_FRAC_BITS]));
      py_d[k] = CW'($signed({cy_q, 1'b0})) + CW'($signed(ry[PW:TRIG_FRAC_BITS]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q  <= px_d;
      py_q  <= py_d;
      ox2_q <= ox_q;
      oy2_q <= oy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        dx_q[k] <= DW'(px_q[k]) - DW'($signed({ox2_q, 1'b0}));
        dy_q[k] <= DW'(py_q[k]) - DW'($signed({oy2_q, 1'b0}));
      end
    end
  end

  assign dx_o = dx_q;
  assign dy_o = dy_q;

endmodule

[rtl/orov_inside.sv]
// ----------------------------------------------------------------------------
// orov_inside
// Rotates corner offsets into a rectangle frame and checks the extents.
// ----------------------------------------------------------------------------
module orov_inside #(
  parameter int COORD_WIDTH    = orov_pkg::COORD_WIDTH,
  parameter int TRIG_FRAC_BITS = orov_pkg::TRIG_FRAC_BITS,
  localparam int DW            = COORD_WIDTH + 5
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [DW-1:0]             dx_i [4],
  input  logic signed [DW-1:0]             dy_i [4],
  input  logic        [COORD_WIDTH-2:0]    width_i,
  input  logic        [COORD_WIDTH-2:0]    height_i,
  input  logic signed [TRIG_FRAC_BITS+1:0] sin_i,
  input  logic signed [TRIG_FRAC_BITS+1:0] cos_i,
  output logic        [3:0]                inside_o
);

  localparam int PW = DW + TRIG_FRAC_BITS + 2;
  localparam int RW = PW + 1;

  logic signed [PW-1:0]          xc_q [4], ys_q [4], yc_q [4], xs_q [4];
  logic        [COORD_WIDTH-2:0] w_q, h_q;
  logic        [3:0]             inside_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        xc_q[k] <= dx_i[k] * cos_i;
        ys_q[k] <= dy_i[k] * sin_i;
        yc_q[k] <= dy_i[k] * cos_i;
        xs_q[k] <= dx_i[k] * sin_i;
      end
      w_q <= width_i;
      h_q <= height_i;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [RW-1:0] rx, ry, lx, ly;
    if (en_i) begin
      lx = $signed(RW'({w_q, TRIG_FRAC_BITS'(0)}));
      ly = $signed(RW'({h_q, TRIG_FRAC_BITS'(0)}));
      for (int k = 0; k < 4; k++) begin
        rx = RW'(xc_q[k]) - RW'(ys_q[k]);
        ry = RW'(yc_q[k]) + RW'(xs_q[k]);
        inside_q[k] <= (rx >= -lx) && (rx <= lx) && (ry >= -ly) && (ry <= ly);
      end
    end
  end

  assign inside_o = inside_q;

endmodule

[rtl/orov_checker.sv]
// ----------------------------------------------------------------------------
// orov_checker
// Port-level checks on the overlap block, bound to the top level.
// ----------------------------------------------------------------------------
module orov_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input orov_pkg::orov_out_req_t out_req_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_req_o))
    else $error("result request dropped or changed while stalled");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  a_covers_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !out_req_o.covers_flag || out_req_o.overlap_flag)
    else $error("covers without overlap");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i)
    else $error("input request withdrawn before acceptance");

endmodule

bind oriented_rectangle_overlap_top orov_checker u_orov_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_req_o   (out_req_o)
);

[verif/tb_oriented_rectangle_overlap_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_oriented_rectangle_overlap_top
// Self-checking testbench for the oriented rectangle overlap block.
// ----------------------------------------------------------------------------
// A queue of rectangle pairs feeds a clocked driver; a clocked monitor checks
// each returned flag pair against a corner containment predictor that works
// in doubled fixed point with its own quarter-wave sine table. Directed pairs
// come first, then random pairs, over four phases of sender idling and
// receiver stalling.
// ----------------------------------------------------------------------------
module tb_oriented_rectangle_overlap_top;

  localparam int TRIG_ONE = 1 << orov_pkg::TRIG_FRAC_BITS;
  localparam int QUARTER  = 1 << (orov_pkg::ANGLE_BITS - 2);
  localparam int CRD_W    = orov_pkg::COORD_WIDTH;
  localparam int ANG_W    = orov_pkg::ANGLE_BITS;

  typedef struct {
    longint cx;
    longint cy;
    longint w;
    longint h;
    int     ang;
  } rect_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  orov_pkg::orov_in_req_t  in_req_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  orov_pkg::orov_out_req_t out_req_o;

  orov_pkg::orov_in_req_t  pair_queue[$];
  orov_pkg::orov_out_req_t flags_expected[$];
  longint                  sine_rom[0:QUARTER];
  int                      idle_pct;
  int                      stall_pct;
  int                      mismatch_count;
  int                      checked_count;
  int                      overlap_seen;
  int                      covers_seen;

  oriented_rectangle_overlap_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_req_o  (out_req_o)
  );

  function automatic longint sine_at(int a);
    int q;
    int r;
    q = (a >> (orov_pkg::ANGLE_BITS - 2)) & 3;
    r = a & (QUARTER - 1);
    case (q)
      0: return sine_rom[r];
      1: return sine_rom[QUARTER - r];
      2: return -sine_rom[r];
      default: return -sine_rom[QUARTER - r];
    endcase
  endfunction

  function automatic longint cosine_at(int a);
    return sine_at((a + QUARTER) & ((1 << orov_pkg::ANGLE_BITS) - 1));
  endfunction

  function automatic longint round_trig(longint v);
    return (v + (TRIG_ONE / 2)) >>> orov_pkg::TRIG_FRAC_BITS;
  endfunction

  // corners of b lying inside a
  function automatic int corners_within(rect_t a, rect_t b);
    longint sb, cb, sa, ca, u, v, px, py, dx, dy, rx, ry, limx, limy;
    int     n;
    sb = sine_at(b.ang);
    cb = cosine_at(b.ang);
    sa = sine_at(a.ang);
    ca = cosine_at(a.ang);
    limx = a.w * TRIG_ONE;
    limy = a.h * TRIG_ONE;
    n = 0;
    for (int k = 0; k < 4; k++) begin
      u = (k & 1) ? b.w : -b.w;
      v = (k & 2) ? -b.h : b.h;
      px = b.cx + round_trig(u * cb + v * sb);
      py = b.cy + round_trig(v * cb - u * sb);
      dx = px - a.cx;
      dy = py - a.cy;
      rx = dx * ca - dy * sa;
      ry = dy * ca + dx * sa;
      if (rx >= -limx && rx <= limx && ry >= -limy && ry <= limy) n++;
    end
    return n;
  endfunction

  function automatic orov_pkg::orov_out_req_t overlap_flags(orov_pkg::orov_in_req_t p);
    rect_t                   f, s;
    int                      n;
    orov_pkg::orov_out_req_t res;
    f.cx = 2 * longint'(p.first_center_x);
    f.cy = 2 * longint'(p.first_center_y);
    f.w = p.first_width;
    f.h = p.first_height;
    f.ang = p.first_angle;
    s.cx = 2 * longint'(p.second_center_x);
    s.cy = 2 * longint'(p.second_center_y);
    s.w = p.second_width;
    s.h = p.second_height;
    s.ang = p.second_angle;
    n = corners_within(f, s);
    res.overlap_flag = (n > 0) || (corners_within(s, f) > 0);
    res.covers_flag = (n == 4);
    return res;
  endfunction

  function automatic orov_pkg::orov_in_req_t make_pair(int cx1, int cy1, int w1, int h1,
                                                       int a1, int cx2, int cy2, int w2,
                                                       int h2, int a2);
    orov_pkg::orov_in_req_t p;
    p.first_center_x = CRD_W'(cx1);
    p.first_center_y = CRD_W'(cy1);
    p.first_width = (CRD_W-1)'(w1);
    p.first_height = (CRD_W-1)'(h1);
    p.first_angle = ANG_W'(a1);
    p.second_center_x = CRD_W'(cx2);
    p.second_center_y = CRD_W'(cy2);
    p.second_width = (CRD_W-1)'(w2);
    p.second_height = (CRD_W-1)'(h2);
    p.second_angle = ANG_W'(a2);
    return p;
  endfunction

  function automatic int rand_extent();
    case ($urandom_range(3))
      0: return $urandom_range(63);
      1: return $urandom_range(1023);
      2: return $urandom_range(8191);
      default: return $urandom_range(32767);
    endcase
  endfunction

  function automatic orov_pkg::orov_in_req_t rand_pair();
    orov_pkg::orov_in_req_t p;
    logic [191:0]           raw;
    int                     cx, cy, spread;
    if ($urandom_range(3) == 0) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      p = raw[$bits(orov_pkg::orov_in_req_t)-1:0];
    end else begin
      spread = 1 << $urandom_range(6, 15);
      cx = $signed($urandom_range(32000)) - 16000;
      cy = $signed($urandom_range(32000)) - 16000;
      p = make_pair(cx, cy, rand_extent(), rand_extent(), $urandom_range(4095),
                    cx + $signed($urandom_range(spread)) - spread / 2,
                    cy + $signed($urandom_range(spread)) - spread / 2,
                    rand_extent(), rand_extent(), $urandom_range(4095));
    end
    return p;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("FAIL oriented_rectangle_overlap_top");
    $finish;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
    end else if (!in_valid_i || in_ready_o) begin
      if (pair_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_req_i   <= pair_queue.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    orov_pkg::orov_out_req_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
      if (in_valid_i && in_ready_o) flags_expected.push_back(overlap_flags(in_req_i));
      if (out_valid_o && out_ready_i) begin
        if (flags_expected.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result %b", out_req_o);
        end else begin
          want = flags_expected.pop_front();
          checked_count++;
          overlap_seen += out_req_o.overlap_flag;
          covers_seen += out_req_o.covers_flag;
          if (out_req_o !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: overlap exp %b got %b, covers exp %b got %b",
                       want.overlap_flag, out_req_o.overlap_flag,
                       want.covers_flag, out_req_o.covers_flag);
          end
        end
      end
    end
  end

  initial begin
    int idle_set[4];
    int stall_set[4];
    idle_set = '{0, 74, 0, 33};
    stall_set = '{0, 0, 74, 33};
    mismatch_count = 0;
    checked_count = 0;
    overlap_seen = 0;
    covers_seen = 0;
    idle_pct = 0;
    stall_pct = 0;
    for (int r = 0; r <= QUARTER; r++)
      sine_rom[r] = longint'($floor($sin(3.14159265358979323846 * r / (2.0 * QUARTER))
                                    * TRIG_ONE + 0.5));
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed pairs
    pair_queue.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pair_queue.push_back(make_pair(0, 0, 160, 160, 0, 0, 0, 80, 80, 0));
    pair_queue.push_back(make_pair(0, 0, 160, 16, 0, 0, 0, 16, 160, 0));
    pair_queue.push_back(make_pair(0, 0, 160, 16, 0, 0, 0, 160, 16, 1024));
    pair_queue.push_back(make_pair(0, 0, 100, 100, 512, 0, 0, 100, 100, 0));
    pair_queue.push_back(make_pair(0, 0, 100, 100, 0, 100, 100, 100, 100, 0));
    pair_queue.push_back(make_pair(0, 0, 100, 100, 0, 201, 0, 100, 100, 0));
    pair_queue.push_back(make_pair(0, 0, 0, 100, 0, 0, 50, 0, 0, 0));
    pair_queue.push_back(make_pair(0, 0, 100, 0, 2048, 0, 0, 0, 100, 3072));
    pair_queue.push_back(make_pair(-32768, -32768, 32767, 32767, 4095,
                                   32767, 32767, 32767, 32767, 4095));
    pair_queue.push_back(make_pair(32767, -32768, 32767, 0, 1024,
                                   -32768, 32767, 0, 32767, 3072));
    pair_queue.push_back(make_pair(0, 0, 32767, 32767, 0, 0, 0, 32767, 32767, 2048));
    pair_queue.push_back(make_pair(-32768, 32767, 1, 1, 1, -32768, 32767, 32767, 32767, 2047));
    pair_queue.push_back(make_pair(1000, -1000, 500, 300, 300, 1100, -900, 100, 50, 3000));
    pair_queue.push_back(make_pair(0, 0, 32767, 32767, 1023, 32767, 32767, 0, 0, 0));
    pair_queue.push_back(make_pair(5, 5, 3, 3, 4095, -5, -5, 3, 3, 1));

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_set[ph];
      stall_pct = stall_set[ph];
      repeat (212) pair_queue.push_back(rand_pair());
      do @(posedge clk_i);
      while (pair_queue.size() > 0 || in_valid_i || flags_expected.size() > 0);
    end
    stall_pct = 0;
    repeat (20) @(posedge clk_i);

    $display("checked %0d rectangle pairs over four idling phases", checked_count);
    $display("overlap flagged %0d times, covers flagged %0d times, %0d mismatches",
             overlap_seen, covers_seen, mismatch_count);
    if (mismatch_count == 0 && flags_expected.size() == 0) begin
      $display("PASS oriented_rectangle_overlap_top");
    end else begin
      $display("FAIL oriented_rectangle_overlap_top");
    end
    $finish;
  end

endmodule

[oriented_rectangle_overlap_top.f]
rtl/orov_pkg.sv
rtl/orov_trig.sv
rtl/orov_corners.sv
rtl/orov_inside.sv
rtl/oriented_rectangle_overlap_top.sv
rtl/orov_checker.sv
verif/tb_oriented_rectangle_overlap_top.sv
